// ===== hw/rtl/sid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sid_pkg: shared types and widths for the segment intersection unit.
// The widths follow from the coordinate width and cover every exact
// intermediate product, sum and quotient.
// ----------------------------------------------------------------------------
package sid_pkg;

  // Coordinate and intermediate widths.
  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int PdBits    = CoordBits + CrossBits;
  localparam int TaBits    = CrossBits + DiffBits;
  localparam int NumBits   = TaBits + 1;
  localparam int QuoBits   = CoordBits;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [CrossBits-1:0] cross_t;
  typedef logic        [CrossBits-1:0] den_t;
  typedef logic signed [PdBits-1:0]    pd_t;
  typedef logic signed [TaBits-1:0]    ta_t;
  typedef logic signed [NumBits-1:0]   num_t;
  typedef logic        [NumBits-1:0]   mag_t;
  typedef logic        [QuoBits-1:0]   quo_t;

  // Control bits that travel with an item down the divider.
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sid_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sid_front: arithmetic front end of the segment intersection unit.
// Five register stages: differences, products, cross terms with sign
// normalization, range test with point products, and point numerators.
// ----------------------------------------------------------------------------
module sid_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  in_valid_i,
  input  wire sid_pkg::coord_t a_start_x_i,
  input  wire sid_pkg::coord_t a_start_y_i,
  input  wire sid_pkg::coord_t a_end_x_i,
  input  wire sid_pkg::coord_t a_end_y_i,
  input  wire sid_pkg::coord_t b_start_x_i,
  input  wire sid_pkg::coord_t b_start_y_i,
  input  wire sid_pkg::coord_t b_end_x_i,
  input  wire sid_pkg::coord_t b_end_y_i,
  output sid_pkg::ctl_t        ctl_o,
  output sid_pkg::mag_t        mag_x_o,
  output sid_pkg::mag_t        mag_y_o,
  output sid_pkg::den_t        den_o
);
  import sid_pkg::*;

  logic   s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  diff_t  ax_q, ay_q, bx_q, by_q, wx_q, wy_q;
  coord_t s1_p0x_q, s1_p0y_q;
  prod_t  p_axby_q, p_bxay_q, p_axwy_q, p_aywx_q, p_bxwy_q, p_bywx_q;
  diff_t  s2_ax_q, s2_ay_q;
  coord_t s2_p0x_q, s2_p0y_q;
  cross_t den_raw, sn_raw, tn_raw;
  cross_t s3_den_q, s3_sn_q, s3_tn_q;
  logic   s3_zero_q;
  diff_t  s3_ax_q, s3_ay_q;
  coord_t s3_p0x_q, s3_p0y_q;
  logic   s4_hit_d, s4_hit_q;
  pd_t    pdx_q, pdy_q;
  ta_t    tax_q, tay_q;
  den_t   s4_den_q;
  num_t   nx, ny;
  ctl_t   ctl_q;
  mag_t   mag_x_q, mag_y_q;
  den_t   den_q;

  // Valid bits for stages 1 to 4; stage 5 carries valid in ctl_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // Stage 1: direction vectors and start offset.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q     <= diff_t'(a_end_x_i) - diff_t'(a_start_x_i);
      ay_q     <= diff_t'(a_end_y_i) - diff_t'(a_start_y_i);
      bx_q     <= diff_t'(b_end_x_i) - diff_t'(b_start_x_i);
      by_q     <= diff_t'(b_end_y_i) - diff_t'(b_start_y_i);
      wx_q     <= diff_t'(a_start_x_i) - diff_t'(b_start_x_i);
      wy_q     <= diff_t'(a_start_y_i) - diff_t'(b_start_y_i);
      s1_p0x_q <= a_start_x_i;
      s1_p0y_q <= a_start_y_i;
    end
  end

  // Stage 2: the six cross-product terms.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_axby_q <= ax_q * by_q;
      p_bxay_q <= bx_q * ay_q;
      p_axwy_q <= ax_q * wy_q;
      p_aywx_q <= ay_q * wx_q;
      p_bxwy_q <= bx_q * wy_q;
      p_bywx_q <= by_q * wx_q;
      s2_ax_q  <= ax_q;
      s2_ay_q  <= ay_q;
      s2_p0x_q <= s1_p0x_q;
      s2_p0y_q <= s1_p0y_q;
    end
  end

  // Stage 3: denominator and numerators, sign-normalized so den is positive.
  assign den_raw = cross_t'(p_axby_q) - cross_t'(p_bxay_q);
  assign sn_raw  = cross_t'(p_axwy_q) - cross_t'(p_aywx_q);
  assign tn_raw  = cross_t'(p_bxwy_q) - cross_t'(p_bywx_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_den_q  <= den_raw[CrossBits-1] ? -den_raw : den_raw;
      s3_sn_q   <= den_raw[CrossBits-1] ? -sn_raw : sn_raw;
      s3_tn_q   <= den_raw[CrossBits-1] ? -tn_raw : tn_raw;
      s3_zero_q <= (den_raw == '0);
      s3_ax_q   <= s2_ax_q;
      s3_ay_q   <= s2_ay_q;
      s3_p0x_q  <= s2_p0x_q;
      s3_p0y_q  <= s2_p0y_q;
    end
  end

  // Stage 4: range test on s and t, and the point products.
  assign s4_hit_d = !s3_zero_q && !s3_sn_q[CrossBits-1] && (s3_sn_q <= s3_den_q)
                    && !s3_tn_q[CrossBits-1] && (s3_tn_q <= s3_den_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_hit_q <= s4_hit_d;
      pdx_q    <= s3_p0x_q * s3_den_q;
      pdy_q    <= s3_p0y_q * s3_den_q;
      tax_q    <= s3_tn_q * s3_ax_q;
      tay_q    <= s3_tn_q * s3_ay_q;
      s4_den_q <= den_t'(s3_den_q);
    end
  end

  // Stage 5: point numerators split into sign and magnitude.
  assign nx = num_t'(pdx_q) + num_t'(tax_q);
  assign ny = num_t'(pdy_q) + num_t'(tay_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid <= s4_valid_q;
      ctl_q.hit   <= s4_valid_q && s4_hit_q;
      ctl_q.neg_x <= nx[NumBits-1];
      ctl_q.neg_y <= ny[NumBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_x_q <= mag_t'(nx[NumBits-1] ? -nx : nx);
      mag_y_q <= mag_t'(ny[NumBits-1] ? -ny : ny);
      den_q   <= s4_den_q;
    end
  end

  assign ctl_o   = ctl_q;
  assign mag_x_o = mag_x_q;
  assign mag_y_o = mag_y_q;
  assign den_o   = den_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sid_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sid_divider: pipelined restoring divider for both point coordinates.
// One quotient bit per stage, most significant first; the magnitude is
// known to stay below den shifted by the quotient width.
// ----------------------------------------------------------------------------
module sid_divider (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                en_i,
  input  wire sid_pkg::ctl_t ctl_i,
  input  wire sid_pkg::mag_t mag_x_i,
  input  wire sid_pkg::mag_t mag_y_i,
  input  wire sid_pkg::den_t den_i,
  output sid_pkg::ctl_t      ctl_o,
  output sid_pkg::quo_t      quo_x_o,
  output sid_pkg::quo_t      quo_y_o
);
  import sid_pkg::*;

  ctl_t ctl_q   [QuoBits];
  mag_t rem_x_q [QuoBits-1];
  mag_t rem_y_q [QuoBits-1];
  quo_t quo_x_q [QuoBits];
  quo_t quo_y_q [QuoBits];
  den_t den_q   [QuoBits-1];

  for (genvar k = 0; k < QuoBits; k++) begin : g_stage
    localparam int Shift = QuoBits - 1 - k;
    ctl_t ctl_in;
    mag_t rx_in, ry_in, dsh;
    quo_t qx_in, qy_in;
    den_t den_in;
    logic ge_x, ge_y;

    // Stage inputs come from the front end or the stage before.
    if (k == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign rx_in  = mag_x_i;
      assign ry_in  = mag_y_i;
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign ctl_in = ctl_q[k-1];
      assign rx_in  = rem_x_q[k-1];
      assign ry_in  = rem_y_q[k-1];
      assign qx_in  = quo_x_q[k-1];
      assign qy_in  = quo_y_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Trial subtraction of the shifted denominator.
    assign dsh  = mag_t'(den_in) << Shift;
    assign ge_x = (rx_in >= dsh);
    assign ge_y = (ry_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_x_q[k] <= {qx_in[QuoBits-2:0], ge_x};
        quo_y_q[k] <= {qy_in[QuoBits-2:0], ge_y};
      end
    end

    // Remainder and divisor move on only where a later stage reads them.
    if (k < QuoBits - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_x_q[k] <= ge_x ? rx_in - dsh : rx_in;
          rem_y_q[k] <= ge_y ? ry_in - dsh : ry_in;
          den_q[k]   <= den_in;
        end
      end
    end
  end

  assign ctl_o   = ctl_q[QuoBits-1];
  assign quo_x_o = quo_x_q[QuoBits-1];
  assign quo_y_o = quo_y_q[QuoBits-1];

endmodule
`default_nettype wire

// ===== hw/rtl/segment_intersection_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_unit: parametric intersection of two 2-D segments.
// Reports a hit and the intersection point in signed Q12.4.
// ----------------------------------------------------------------------------
// The unit accepts one segment pair every cycle unless a result waits on a
// stalled output; each pair passes five arithmetic stages, sixteen divider
// stages (one quotient bit each) and the output register. Touching at an
// endpoint counts as a hit; parallel, collinear and degenerate segments give
// no hit, and a result without a hit carries a zero point. A stall on the
// output holds the whole pipeline, so no item is lost or repeated.
module segment_intersection_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire sid_pkg::coord_t a_start_x_i,
  input  wire sid_pkg::coord_t a_start_y_i,
  input  wire sid_pkg::coord_t a_end_x_i,
  input  wire sid_pkg::coord_t a_end_y_i,
  input  wire sid_pkg::coord_t b_start_x_i,
  input  wire sid_pkg::coord_t b_start_y_i,
  input  wire sid_pkg::coord_t b_end_x_i,
  input  wire sid_pkg::coord_t b_end_y_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 hit_o,
  output sid_pkg::coord_t      cross_x_o,
  output sid_pkg::coord_t      cross_y_o
);
  import sid_pkg::*;

  logic   en;
  ctl_t   fe_ctl, dv_ctl;
  mag_t   fe_mag_x, fe_mag_y;
  den_t   fe_den;
  quo_t   quo_x, quo_y;
  logic   out_valid_q, hit_q;
  coord_t cross_x_d, cross_y_d, cross_x_q, cross_y_q;

  // The pipeline advances unless a finished item waits on a stalled output.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  sid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .ctl_o       (fe_ctl),
    .mag_x_o     (fe_mag_x),
    .mag_y_o     (fe_mag_y),
    .den_o       (fe_den)
  );

  sid_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (fe_ctl),
    .mag_x_i (fe_mag_x),
    .mag_y_i (fe_mag_y),
    .den_i   (fe_den),
    .ctl_o   (dv_ctl),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  // Restore the sign of the quotient and zero the point on a miss.
  always_comb begin
    cross_x_d = '0;
    cross_y_d = '0;
    if (dv_ctl.hit) begin
      cross_x_d = coord_t'(dv_ctl.neg_x ? -quo_x : quo_x);
      cross_y_d = coord_t'(dv_ctl.neg_y ? -quo_y : quo_y);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_ctl.valid;
      hit_q       <= dv_ctl.valid && dv_ctl.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cross_x_q <= cross_x_d;
      cross_y_q <= cross_y_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign cross_x_o   = cross_x_q;
  assign cross_y_o   = cross_y_q;

  // A miss always carries a zero point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> cross_x_o == '0 && cross_y_o == '0)
    else $error("miss with nonzero point");

  // The input is held off only by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without cause");

  // A hit is flagged only on a valid item.
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> out_valid_o)
    else $error("hit without valid item");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the segment intersection unit.
// Segment pairs go in through the valid/stall input channel. A scoreboard
// works out the expected hit flag and crossing point for each accepted item
// with exact wide integer math and compares them with the results in order.
// ----------------------------------------------------------------------------

// Expected results in order, with the predictor of the crossing test.
class crossing_board;
  typedef struct {
    logic hit;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } crossing_t;

  crossing_t pending[$];
  int errors;
  int hits;
  int checked;

  function new();
    errors = 0;
    hits = 0;
    checked = 0;
  endfunction

  // Signed division truncated toward zero, with a positive divisor.
  function logic signed [127:0] div_trunc(logic signed [127:0] n, logic signed [127:0] d);
    logic signed [127:0] m;
    m = (n < 0) ? -n : n;
    m = m / d;
    return (n < 0) ? -m : m;
  endfunction

  // Note an accepted segment pair and queue what it should produce.
  function void note_pair(logic signed [15:0] p[8]);
    logic signed [127:0] ax, ay, bx, by, wx, wy, den, sn, tn, nx, ny;
    crossing_t r;
    ax = 128'(p[2]) - 128'(p[0]);
    ay = 128'(p[3]) - 128'(p[1]);
    bx = 128'(p[6]) - 128'(p[4]);
    by = 128'(p[7]) - 128'(p[5]);
    wx = 128'(p[0]) - 128'(p[4]);
    wy = 128'(p[1]) - 128'(p[5]);
    den = ax * by - bx * ay;
    sn = ax * wy - ay * wx;
    tn = bx * wy - by * wx;
    r.hit = 1'b0;
    r.cx = '0;
    r.cy = '0;
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        sn = -sn;
        tn = -tn;
      end
      if (sn >= 0 && sn <= den && tn >= 0 && tn <= den) begin
        nx = 128'(p[0]) * den + tn * ax;
        ny = 128'(p[1]) * den + tn * ay;
        r.hit = 1'b1;
        r.cx = 16'(div_trunc(nx, den));
        r.cy = 16'(div_trunc(ny, den));
      end
    end
    pending.push_back(r);
  endfunction

  // Compare one result with the oldest expectation.
  function void check_result(logic hit, logic signed [15:0] cx, logic signed [15:0] cy);
    crossing_t e;
    if (pending.size() == 0) begin
      $error("unexpected result hit=%0b x=%0d y=%0d", hit, cx, cy);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (e.hit) hits++;
    if (hit !== e.hit) begin
      $error("hit: expected %0b actual %0b", e.hit, hit);
      errors++;
    end
    if (cx !== e.cx) begin
      $error("cross_x: expected %0d actual %0d", e.cx, cx);
      errors++;
    end
    if (cy !== e.cy) begin
      $error("cross_y: expected %0d actual %0d", e.cy, cy);
      errors++;
    end
  endfunction
endclass

module tb;
  import sid_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  coord_t pt[8];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  coord_t cross_x_o, cross_y_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  crossing_board board;

  initial for (int i = 0; i < 8; i++) pt[i] = '0;

  always #4 clk_i = ~clk_i;

  segment_intersection_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .a_start_x_i(pt[0]), .a_start_y_i(pt[1]), .a_end_x_i(pt[2]), .a_end_y_i(pt[3]),
    .b_start_x_i(pt[4]), .b_start_y_i(pt[5]), .b_end_x_i(pt[6]), .b_end_y_i(pt[7]),
    .out_valid_o, .out_stall_i, .hit_o, .cross_x_o, .cross_y_o
  );

  // Receiver: random stalls and result checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(hit_o, cross_x_o, cross_y_o);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Drive one item, with a random gap first, and wait until it is taken.
  // Valid stays high after the accept; the next gap or a drain lowers it.
  task automatic send_pair(coord_t p[8]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 8; i++) pt[i] <= p[i];
    do @(posedge clk_i); while (in_stall_o);
    board.note_pair(p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(64) - 32);
      default: return coord_t'($urandom_range(1) ? 16'sh7fff : 16'sh8000);
    endcase
  endfunction

  // Random pair: crossing-prone shapes for four kinds in ten, some extremes and degenerates.
  task automatic send_random();
    coord_t p[8];
    int kind, mode;
    kind = $urandom_range(9);
    mode = ($urandom_range(9) == 0) ? 2 : ($urandom_range(1) ? 1 : 0);
    for (int i = 0; i < 8; i++) p[i] = rnd_coord(mode);
    if (kind < 4) begin
      // Build B through a point on A so many pairs hit.
      coord_t mx, my;
      mx = coord_t'((32'(p[0]) + 32'(p[2])) >>> 1);
      my = coord_t'((32'(p[1]) + 32'(p[3])) >>> 1);
      p[6] = coord_t'(2 * 32'(mx) - 32'(p[4]));
      p[7] = coord_t'(2 * 32'(my) - 32'(p[5]));
    end else if (kind == 4) begin
      p[2] = p[0];
      p[3] = p[1];
    end else if (kind == 5) begin
      p[6] = p[4] + (p[2] - p[0]);
      p[7] = p[5] + (p[3] - p[1]);
    end else if (kind == 6) begin
      p[4] = p[2];
      p[5] = p[3];
    end
    send_pair(p);
  endtask

  task automatic run_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) send_random();
  endtask

  initial begin
    coord_t d[8];
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain cross, endpoint touch, parallel, collinear, degenerate, extremes.
    d = '{16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'sd0, 16'sd160, 16'sd160, 16'sd0};
    send_pair(d);
    d = '{16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd80};
    send_pair(d);
    d = '{16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd80};
    send_pair(d);
    d = '{16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0, 16'sd16, 16'sd160, 16'sd16};
    send_pair(d);
    d = '{16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd80, 16'sd0, 16'sd240, 16'sd0};
    send_pair(d);
    d = '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd9, 16'sd9};
    send_pair(d);
    d = '{16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'sd0, 16'sd161, 16'sd160, 16'sd321};
    send_pair(d);
    d = '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
          -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768};
    send_pair(d);
    d = '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
          -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767};
    send_pair(d);
    d = '{-16'sd1, -16'sd1, 16'sd3, 16'sd2, 16'sd2, -16'sd7, -16'sd1, 16'sd5};
    send_pair(d);
    d = '{16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1};
    send_pair(d);
    d = '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd32767};
    send_pair(d);

    run_random(180, 18, 63);
    // Hold off until the pipeline is empty.
    drain();
    run_random(180, 63, 18);
    run_random(180, 0, 0);

    drain();
    repeat (40) @(posedge clk_i);
    $display("Checked %0d results, %0d of them hits, over three idle profiles.",
             board.checked, board.hits);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/sid_pkg.sv
hw/rtl/sid_front.sv
hw/rtl/sid_divider.sv
hw/rtl/segment_intersection_unit.sv
dv/tb.sv
